[rtl/core/rfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types, constants and helpers of the radio frame deframer.
// ----------------------------------------------------------------------------
package rfd_pkg;

  localparam int unsigned MaxFrameBytes = 255;  // legal range 11..255
  localparam int unsigned HeaderBytes   = 11;   // id + type + check
  localparam int unsigned IdBytes       = 8;
  localparam int unsigned FifoDepth     = 4;
  localparam int unsigned PtrW          = $clog2(FifoDepth);
  localparam int unsigned CntW          = $clog2(FifoDepth + 1);

  localparam logic [7:0] KeyReset = 8'd1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHECK = 2'd1,
    ST_SHORT     = 2'd2,
    ST_LONG      = 2'd3
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [63:0] sender_id;
    logic [7:0]  device_type;
    logic [7:0]  payload_length;
    status_e     status;
    logic        last;
  } result_t;

  function automatic logic [7:0] unscramble(input logic [7:0] b, input logic [7:0] k);
    logic [15:0] p;
    p = {8'd0, b} * {8'd0, k};
    return p[7:0];
  endfunction

endpackage

[rtl/core/rfd_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_in_if
// Raw byte channel into the deframer: valid/ready with byte and end mark.
// ----------------------------------------------------------------------------
interface rfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       frame_end;

  modport source (output valid, output raw_byte, output frame_end, input ready);
  modport sink   (input valid, input raw_byte, input frame_end, output ready);
endinterface

[rtl/core/rfd_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_out_if
// Result channel of the deframer: payload bytes and end-of-frame verdicts.
// ----------------------------------------------------------------------------
interface rfd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [63:0] sender_id;
  logic [7:0]  device_type;
  logic [7:0]  payload_length;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output kind, output payload_byte, output payload_index,
                  output sender_id, output device_type, output payload_length,
                  output status, output last, input ready);
  modport sink   (input valid, input kind, input payload_byte, input payload_index,
                  input sender_id, input device_type, input payload_length,
                  input status, input last, output ready);
endinterface

[rtl/core/radio_frame_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_frame_deframer
// Unscrambles and splits received frames into payload bytes and a verdict.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one scrambled byte per transaction, frame_end on the last.
//   out_o carries results: payload bytes (kind 0), delayed by two input
//   bytes so the trailing check is never forwarded, and one verdict
//   (kind 1) per frame with id, type, payload length and status.
//   cfg_we_i/cfg_wdata_i write the unscramble key; write it only while idle.
// Timing:
//   An accepted byte is processed in the cycle it is taken; its results
//   enter a 4-entry result queue and can leave on the next cycle.
//   One byte per cycle is sustained while out_o.ready stays high. The queue drains
//   one result per cycle, so the extra result at a frame end (payload byte plus
//   verdict) is absorbed by the queue.
// Reset: frame state cleared, queue empty, key set to 1.
// Stall: when out_o.ready is low the queue fills; in_i.ready drops once
//   fewer than two queue slots are free, and no result is lost.
// ----------------------------------------------------------------------------
module radio_frame_deframer
  import rfd_pkg::*;
#(
  parameter int unsigned MaxBytes = MaxFrameBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rfd_in_if.sink     in_i,
  rfd_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic [7:0]  key_q;
  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  held0_q, held0_d, held1_q, held1_d;
  logic [63:0] id_q, id_d;
  logic [7:0]  type_q, type_d;
  logic        ovl_q, ovl_d;

  result_t     fifo_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_fifo_q, cnt_fifo_d;

  logic        acc, pop;
  result_t     push_a, push_b;
  logic [1:0]  push_n;

  assign in_i.ready = (cnt_fifo_q <= CntW'(FifoDepth - 2));
  assign acc        = in_i.valid && in_i.ready;
  assign pop        = out_o.valid && out_o.ready;

  // Per-byte frame processing
  always_comb begin
    logic        ovl_now;
    logic [7:0]  d;
    logic [7:0]  q;
    logic        pay_v;
    result_t     pay, verd;
    logic [15:0] check;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    held0_d = held0_q;
    held1_d = held1_q;
    id_d    = id_q;
    type_d  = type_q;
    ovl_now = ovl_q || (cnt_q >= 8'(MaxBytes));
    ovl_d   = ovl_q;
    d       = unscramble(held1_q, key_q);
    q       = cnt_q - 8'd2;
    pay_v   = 1'b0;
    pay     = '0;
    verd    = '0;
    check   = '0;
    push_a  = '0;
    push_b  = '0;
    push_n  = 2'd0;
    if (acc) begin
      ovl_d = ovl_now;
      if (!ovl_now) begin
        if (cnt_q >= 8'd2) begin
          sum_d = sum_q + {8'd0, held1_q};
          if (q < 8'(IdBytes)) begin
            id_d = {id_q[55:0], d};
          end else if (q == 8'(IdBytes)) begin
            type_d = d;
          end else begin
            pay_v              = 1'b1;
            pay.kind           = KIND_PAYLOAD;
            pay.payload_byte   = d;
            pay.payload_index  = q - 8'(IdBytes + 1);
            pay.last           = !in_i.frame_end;
          end
        end
        held1_d = held0_q;
        held0_d = in_i.raw_byte;
        cnt_d   = cnt_q + 8'd1;
      end
      if (in_i.frame_end) begin
        verd.kind = KIND_VERDICT;
        verd.last = 1'b1;
        if (ovl_now) begin
          verd.status         = ST_LONG;
          verd.sender_id      = id_d;
          verd.device_type    = type_d;
          verd.payload_length = 8'(MaxBytes - HeaderBytes);
        end else if (cnt_q < 8'(HeaderBytes - 1)) begin
          verd.status = ST_SHORT;
        end else begin
          check = {unscramble(held1_d, key_q), unscramble(held0_d, key_q)};
          verd.status         = (check == sum_d) ? ST_OK : ST_BAD_CHECK;
          verd.sender_id      = id_d;
          verd.device_type    = type_d;
          verd.payload_length = cnt_q - 8'(HeaderBytes - 1);
        end
        cnt_d   = '0;
        sum_d   = '0;
        held0_d = '0;
        held1_d = '0;
        id_d    = '0;
        type_d  = '0;
        ovl_d   = 1'b0;
      end
      priority if (pay_v && in_i.frame_end) begin
        push_a = pay;
        push_b = verd;
        push_n = 2'd2;
      end else if (pay_v) begin
        push_a = pay;
        push_n = 2'd1;
      end else if (in_i.frame_end) begin
        push_a = verd;
        push_n = 2'd1;
      end else begin
        push_n = 2'd0;
      end
    end
  end

  assign cnt_fifo_d = cnt_fifo_q + CntW'(push_n) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      <= KeyReset;
      cnt_q      <= '0;
      sum_q      <= '0;
      held0_q    <= '0;
      held1_q    <= '0;
      id_q       <= '0;
      type_q     <= '0;
      ovl_q      <= 1'b0;
      wr_q       <= '0;
      rd_q       <= '0;
      cnt_fifo_q <= '0;
    end else begin
      if (cfg_we_i) begin
        key_q <= cfg_wdata_i;
      end
      cnt_q      <= cnt_d;
      sum_q      <= sum_d;
      held0_q    <= held0_d;
      held1_q    <= held1_d;
      id_q       <= id_d;
      type_q     <= type_d;
      ovl_q      <= ovl_d;
      wr_q       <= wr_q + PtrW'(push_n);
      rd_q       <= rd_q + PtrW'(pop);
      cnt_fifo_q <= cnt_fifo_d;
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_q] <= push_a;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_q + PtrW'(1)] <= push_b;
    end
  end

  assign out_o.valid          = (cnt_fifo_q != '0);
  assign out_o.kind           = fifo_q[rd_q].kind;
  assign out_o.payload_byte   = fifo_q[rd_q].payload_byte;
  assign out_o.payload_index  = fifo_q[rd_q].payload_index;
  assign out_o.sender_id      = fifo_q[rd_q].sender_id;
  assign out_o.device_type    = fifo_q[rd_q].device_type;
  assign out_o.payload_length = fifo_q[rd_q].payload_length;
  assign out_o.status         = fifo_q[rd_q].status;
  assign out_o.last           = fifo_q[rd_q].last;

  // Queue never overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_fifo_q <= CntW'(FifoDepth))
    else $error("result queue overflow");

  // A verdict always closes the results of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == KIND_VERDICT) |-> out_o.last)
    else $error("verdict without last");

  // Frame end clears the frame state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_i.frame_end) |=> (cnt_q == '0 && !ovl_q && sum_q == '0))
    else $error("frame state not cleared after frame end");

  // Occupancy follows pushes and pops
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_fifo_q == $past(cnt_fifo_q) + CntW'($past(push_n)) - CntW'($past(pop)))
    else $error("result queue count mismatch");

endmodule
